[sv/fpsd_pkg.sv]
// Package with shared constants and types of the flight phase step detector.
`default_nettype none

package fpsd_pkg;

  localparam int WINDOW_DEF      = 30;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int THR_W           = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd5;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_LIFT  = 2'd1;
  localparam logic [1:0] EV_CUT   = 2'd2;

  localparam logic [1:0] PH_GROUND = 2'd0;
  localparam logic [1:0] PH_LIFT   = 2'd1;
  localparam logic [1:0] PH_CUT    = 2'd2;

  typedef struct packed {
    logic va;
    logic vb;
    logic chk;
  } s1_ctl_t;

endpackage

`default_nettype wire

[sv/fpsd_in_if.sv]
// Sample request channel of the flight phase step detector.
`default_nettype none

interface fpsd_in_if #(
  parameter int SAMPLE_BITS = fpsd_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[sv/fpsd_out_if.sv]
// Result request channel of the flight phase step detector.
`default_nettype none

interface fpsd_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [1:0] phase;

  modport source (output valid, output event_res, output phase, input ready);
  modport sink   (input valid, input event_res, input phase, output ready);
endinterface

`default_nettype wire

[sv/flight_phase_step_detector_unit.sv]
// Top level of the flight phase step detector: sample intake, delay memory, detector.
// An accepted sample request passes the stage one register, then the result register.
// Throughput: one sample per cycle when not stalled; memory: one write, two reads per sample.
// The window difference register feeds back combinationally, so requests follow back to back.
// Reset: synchronous, active low; clears counters, phase, sums and threshold (to 5).
// The delay memory is not cleared; a fill count masks entries not yet written.
`default_nettype none

module flight_phase_step_detector_unit #(
  parameter int WINDOW      = fpsd_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = fpsd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  fpsd_in_if.sink                         in_s,
  fpsd_out_if.source                      out_m,
  input  wire logic                       cfg_we,
  input  wire logic [fpsd_pkg::THR_W-1:0] cfg_wdata
);
  import fpsd_pkg::*;

  localparam int DEPTH = 2 * WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(2 * WINDOW + 3);

  logic [THR_W-1:0]              thr_r;
  logic [AW-1:0]                 wp_r;
  logic [CNT_W-1:0]              seen_r;
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  s1_ctl_t                       s1_ctl_r, s1_ctl_nxt;
  logic                          in_acc, out_free;
  logic [AW:0]                   addr_a_w, addr_b_w;
  logic [AW-1:0]                 addr_a, addr_b;
  logic signed [SAMPLE_BITS-1:0] rd_a, rd_b;

  assign in_s.ready = !s1_valid_r || out_free;
  assign in_acc     = in_s.valid && in_s.ready;

  always_comb begin
    if ({1'b0, wp_r} >= (AW+1)'(WINDOW - 1)) begin
      addr_a_w = {1'b0, wp_r} - (AW+1)'(WINDOW - 1);
    end else begin
      addr_a_w = {1'b0, wp_r} + (AW+1)'(DEPTH - WINDOW + 1);
    end
    if (wp_r == AW'(DEPTH - 1)) begin
      addr_b_w = '0;
    end else begin
      addr_b_w = {1'b0, wp_r} + (AW+1)'(1);
    end
    addr_a = addr_a_w[AW-1:0];
    addr_b = addr_b_w[AW-1:0];
    s1_ctl_nxt.va  = seen_r >= CNT_W'(WINDOW - 1);
    s1_ctl_nxt.vb  = seen_r >= CNT_W'(DEPTH - 1);
    s1_ctl_nxt.chk = seen_r >= CNT_W'(DEPTH + 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_RESET;
      wp_r       <= '0;
      seen_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        wp_r       <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
        if (seen_r < CNT_W'(DEPTH + 2)) begin
          seen_r <= seen_r + CNT_W'(1);
        end
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_s.sample;
      s1_ctl_r    <= s1_ctl_nxt;
    end
  end

  fpsd_delay_mem #(
    .DW    (SAMPLE_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (in_acc),
    .waddr   (wp_r),
    .wdata   (in_s.sample),
    .re      (in_acc),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  fpsd_detect #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_ctl    (s1_ctl_r),
    .s1_sample (s1_sample_r),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .threshold (thr_r),
    .out_ready (out_m.ready),
    .out_free  (out_free),
    .out_valid (out_m.valid),
    .out_event (out_m.event_res),
    .out_phase (out_m.phase)
  );

  a_lift_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_m.valid && out_m.event_res == EV_LIFT) |-> out_m.phase == PH_LIFT)
    else $error("liftoff event without liftoff phase");

  a_cut_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_m.valid && out_m.event_res == EV_CUT) |-> out_m.phase == PH_CUT)
    else $error("cutoff event without cutoff phase");

  a_accept_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted request not held in stage one");

  a_stage_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_free) |=> out_m.valid)
    else $error("stage one request lost before result register");

endmodule

`default_nettype wire

[sv/fpsd_delay_mem.sv]
// Sample delay memory: one write port, two registered read ports.
`default_nettype none

module fpsd_delay_mem #(
  parameter int DW    = 16,
  parameter int DEPTH = 60,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_a,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[sv/fpsd_detect.sv]
// Window difference update, threshold check, phase state and result register.
`default_nettype none

module fpsd_detect #(
  parameter int WINDOW      = fpsd_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = fpsd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s1_valid,
  input  wire fpsd_pkg::s1_ctl_t             s1_ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] s1_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] rd_a,
  input  wire logic signed [SAMPLE_BITS-1:0] rd_b,
  input  wire logic [fpsd_pkg::THR_W-1:0]    threshold,
  input  wire logic                          out_ready,
  output logic                               out_free,
  output logic                               out_valid,
  output logic [1:0]                         out_event,
  output logic [1:0]                         out_phase
);
  import fpsd_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + $clog2(WINDOW) + 2;
  localparam int TS_W   = THR_W + $clog2(WINDOW + 1);
  localparam int CMP_W  = ((DIFF_W > TS_W) ? DIFF_W : TS_W) + 1;
  localparam int STEP_W = SAMPLE_BITS + 2;

  logic signed [DIFF_W-1:0]      diff_r, diff_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r, a_v, b_v;
  logic [1:0]                    phase_r, phase_nxt, ev_nxt;
  logic [TS_W-1:0]               thr_scaled_r;
  logic                          out_valid_r;
  logic [1:0]                    out_event_r, out_phase_r;
  logic signed [STEP_W-1:0]      step;
  logic signed [CMP_W-1:0]       dc, thr_c;
  logic                          take, lift, cut;

  assign out_free = !out_valid_r || out_ready;
  assign take     = s1_valid && out_free;

  always_comb begin
    a_v      = s1_ctl.va ? rd_a : '0;
    b_v      = s1_ctl.vb ? rd_b : '0;
    step     = (STEP_W'(s1_sample) - STEP_W'(prev_r)) - (STEP_W'(a_v) - STEP_W'(b_v));
    diff_nxt = diff_r + DIFF_W'(step);
    dc       = CMP_W'(diff_nxt);
    thr_c    = CMP_W'(signed'({1'b0, thr_scaled_r}));
    lift     = dc >= thr_c;
    cut      = (-dc) >= thr_c;
    phase_nxt = phase_r;
    ev_nxt    = EV_NONE;
    if (s1_ctl.chk) begin
      if (lift && phase_r != PH_LIFT) begin
        phase_nxt = PH_LIFT;
        ev_nxt    = EV_LIFT;
      end else if (cut && phase_r != PH_CUT) begin
        phase_nxt = PH_CUT;
        ev_nxt    = EV_CUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r       <= '0;
      prev_r       <= '0;
      phase_r      <= PH_GROUND;
      out_valid_r  <= 1'b0;
      thr_scaled_r <= TS_W'(THR_RESET) * TS_W'(WINDOW);
    end else begin
      thr_scaled_r <= TS_W'(threshold) * TS_W'(WINDOW);
      if (take) begin
        diff_r      <= diff_nxt;
        prev_r      <= a_v;
        phase_r     <= phase_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_event_r <= ev_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_event = out_event_r;
  assign out_phase = out_phase_r;

endmodule

`default_nettype wire
